>>> hw/rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, constants and the lead byte classifier.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CHAR_W      = 32;
    localparam int unsigned PEND_W      = 3;
    localparam int unsigned SHIFT_W     = 5;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] TOP_BIT     = 8'h80;
    localparam logic [CHAR_W-1:0] REPLACEMENT = 32'h0000_FFFD;
    localparam logic [SHIFT_W-1:0] BITS_PER_CHUNK = 5'd6;

    typedef struct packed {
        logic [1:0]        num;
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
    } t_result;

    function automatic logic [BYTE_W-1:0] class_mask(input logic [PEND_W-1:0] cls);
        logic [BYTE_W-1:0] mask;
        if (cls == '0) begin
            mask = '0;
        end else begin
            mask = 8'hFF << (3'd7 - cls);
        end
        return mask;
    endfunction

    function automatic logic [PEND_W-1:0] lead_class(
        input logic [BYTE_W-1:0] b,
        input int unsigned       max_seq
    );
        logic [PEND_W-1:0] cls;
        logic              found;
        cls   = '0;
        found = 1'b0;
        for (int k = 5; k > 0; k--) begin
            if (!found && k < max_seq &&
                (class_mask(PEND_W'(k)) & b) == class_mask(PEND_W'(k))) begin
                cls   = PEND_W'(k);
                found = 1'b1;
            end
        end
        return cls;
    endfunction

endpackage

>>> hw/rtl/utf8d_core.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Holds the sequence state and turns one byte into up to two characters.
// ----------------------------------------------------------------------------
module utf8d_core
    import utf8d_pkg::*;
#(
    parameter int unsigned MAX_SEQUENCE_BYTES = 6,
    parameter int unsigned COUNT_BITS         = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_result
);

    logic [PEND_W-1:0]     r_pending, n_pending;
    logic [CHAR_W-1:0]     r_acc, n_acc;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic [PEND_W-1:0]     cls;
    logic [PEND_W-1:0]     pend_dec;
    logic [CHAR_W-1:0]     acc_sum;
    logic [CHAR_W-1:0]     count_word;
    logic [BYTE_W-1:0]     payload;

    always_comb begin
        cls        = lead_class(i_byte, MAX_SEQUENCE_BYTES);
        payload    = i_byte ^ class_mask(cls);
        pend_dec   = r_pending - 3'd1;
        acc_sum    = r_acc + (CHAR_W'(i_byte & ~TOP_BIT)
                              << (SHIFT_W'(pend_dec) * BITS_PER_CHUNK));
        count_word = CHAR_W'(r_count);

        n_pending = r_pending;
        n_acc     = r_acc;
        n_count   = r_count;
        o_result  = '{num: 2'd0, first: '0, second: '0};

        if (i_valid) begin
            if (i_byte == '0) begin
                if (r_pending != '0) begin
                    o_result = '{num: 2'd2, first: REPLACEMENT, second: count_word};
                end else begin
                    o_result = '{num: 2'd1, first: count_word, second: '0};
                end
                n_pending = '0;
                n_acc     = '0;
                n_count   = '0;
            end else if (r_pending != '0) begin
                if ((i_byte & TOP_BIT) == '0) begin
                    o_result  = '{num: 2'd1, first: REPLACEMENT, second: '0};
                    n_pending = '0;
                    n_acc     = '0;
                end else begin
                    n_pending = pend_dec;
                    if (pend_dec == '0) begin
                        o_result = '{num: 2'd1, first: acc_sum, second: '0};
                        n_acc    = '0;
                    end else begin
                        n_acc = acc_sum;
                    end
                end
            end else begin
                if (r_count != '1) begin
                    n_count = r_count + 1'b1;
                end
                if (cls == '0) begin
                    o_result = '{num: 2'd1, first: CHAR_W'(i_byte), second: '0};
                end else begin
                    n_acc     = CHAR_W'(payload) << (SHIFT_W'(cls) * BITS_PER_CHUNK);
                    n_pending = cls;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_acc     <= '0;
            r_count   <= '0;
        end else begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_count   <= n_count;
        end
    end

endmodule

>>> hw/rtl/utf8d_fifo.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Small queue that takes up to two characters per cycle and gives one while popped.
// ----------------------------------------------------------------------------
module utf8d_fifo
    import utf8d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_result            i_push,
    input  logic               i_pop,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_data,
    output logic               o_room2
);

    logic [CHAR_W-1:0]  r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, n_wptr;
    logic [FIFO_AW-1:0] r_rptr, n_rptr;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               pop_ok;

    always_comb begin
        pop_ok  = i_pop && (r_count != '0);
        n_wptr  = r_wptr + FIFO_AW'(i_push.num);
        n_rptr  = r_rptr + FIFO_AW'(pop_ok);
        n_count = r_count + FIFO_CW'(i_push.num) - FIFO_CW'(pop_ok);
        o_valid = (r_count != '0);
        o_data  = r_mem[r_rptr];
        o_room2 = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wptr + FIFO_AW'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

>>> hw/rtl/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes legacy UTF-8 sequences of up to six bytes into character values.
//
//   Port group   Dir  Word                  Content
//   s_axis       in   8-bit tdata           one byte of the string
//   m_axis       out  32-bit tdata          character, 0xFFFD, or end count
//
// One byte is taken per cycle while the result queue has room. A byte is held
// in the input register, then the decode logic writes its characters into a
// four-word result queue.
// The input stalls only while the queue holds more than two words.
// Reset is synchronous and clears the sequence state and the queue.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
    import utf8d_pkg::*;
#(
    parameter int unsigned MAX_SEQUENCE_BYTES = 6,
    parameter int unsigned COUNT_BITS         = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BYTE_W-1:0] i_s_axis_tdata,   // [7:0] byte_in
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [CHAR_W-1:0] o_m_axis_tdata    // [31:0] code_point
);

    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              room2;
    logic              process;
    t_result           result;

    always_comb begin
        process         = r_in_valid && room2;
        o_s_axis_tready = !r_in_valid || room2;
        n_in_valid      = (i_s_axis_tvalid && o_s_axis_tready) || (r_in_valid && !process);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    utf8d_core #(
        .MAX_SEQUENCE_BYTES (MAX_SEQUENCE_BYTES),
        .COUNT_BITS         (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (process),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    utf8d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_room2 (room2)
    );

endmodule

>>> hw/rtl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the stream ports of the decoder top level.
// ----------------------------------------------------------------------------
module utf8d_checker
    import utf8d_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic [BYTE_W-1:0] i_s_axis_tdata,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [CHAR_W-1:0] o_m_axis_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("Output valid or input stalled right after reset.");

    a_end_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata == '0 && !o_m_axis_tvalid)
        |-> ##2 o_m_axis_tvalid)
        else $error("End of string was not reported in time.");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("Output valid dropped while stalled.");

    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("Output word changed while stalled.");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> tb/sv/tb_utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds byte strings into the decoder: a directed opening covers plain bytes,
// stray continuation bytes, every sequence length, broken sequences, a zero
// byte inside a sequence and empty strings. After that come random strings of
// mostly well-formed sequences mixed with noise. A scoreboard predicts every
// output word and compares it with what leaves the decoder. Both sides stall
// at random, and the receiver stops once for a long stretch.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_top;
    import utf8d_pkg::*;

    localparam int          COUNT_BITS   = 24;
    localparam int          RANDOM_BYTES = 1150;
    localparam int          LONG_HOLD    = 250;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    class utf8_char_board;
        logic [PEND_W-1:0]     bytes_left;
        logic [CHAR_W-1:0]     char_sum;
        logic [COUNT_BITS-1:0] char_count;
        logic [CHAR_W-1:0]     expected_chars[$];
        int unsigned           mismatches;
        int unsigned           bytes_in;
        int unsigned           words_out;
        int unsigned           strings_ended;
        int unsigned           broken;
        int unsigned           multi_byte;

        function new();
            bytes_left    = '0;
            char_sum      = '0;
            char_count    = '0;
            mismatches    = 0;
            bytes_in      = 0;
            words_out     = 0;
            strings_ended = 0;
            broken        = 0;
            multi_byte    = 0;
        endfunction

        function logic [PEND_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
            if (b[7:2] == 6'b111111) return 3'd5;
            if (b[7:3] == 5'b11111)  return 3'd4;
            if (b[7:4] == 4'b1111)   return 3'd3;
            if (b[7:5] == 3'b111)    return 3'd2;
            if (b[7:6] == 2'b11)     return 3'd1;
            return 3'd0;
        endfunction

        function logic [CHAR_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
                                                  input logic [PEND_W-1:0] len);
            case (len)
                3'd1: begin
                    return 32'(b[4:0]);
                end
                3'd2: begin
                    return 32'(b[3:0]);
                end
                3'd3, 3'd4: begin
                    return 32'(b[2:0]);
                end
                default: begin
                    return 32'(b[1:0]);
                end
            endcase
        endfunction

        function void note_byte(input logic [BYTE_W-1:0] b);
            logic [PEND_W-1:0] len;
            bytes_in++;
            if (b == 8'h00) begin
                if (bytes_left != 0) begin
                    expected_chars.push_back(REPLACEMENT);
                    broken++;
                end
                expected_chars.push_back(32'(char_count));
                strings_ended++;
                bytes_left = '0;
                char_sum   = '0;
                char_count = '0;
                return;
            end
            if (bytes_left != 0) begin
                if ((b & TOP_BIT) == 0) begin
                    expected_chars.push_back(REPLACEMENT);
                    broken++;
                    bytes_left = '0;
                    char_sum   = '0;
                    return;
                end
                bytes_left = bytes_left - 1'b1;
                char_sum   = char_sum + (32'(b[6:0]) << (6 * bytes_left));
                if (bytes_left == 0) begin
                    expected_chars.push_back(char_sum);
                    multi_byte++;
                    char_sum = '0;
                end
                return;
            end
            len = lead_length(b);
            if (char_count != '1) char_count++;
            if (len == 0) begin
                expected_chars.push_back(32'(b));
            end else begin
                char_sum   = lead_payload(b, len) << (6 * len);
                bytes_left = len;
            end
        endfunction

        function void check_word(input logic [CHAR_W-1:0] got);
            logic [CHAR_W-1:0] want;
            words_out++;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual 0x%08h", $time, got);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (got !== want) begin
                $display("%0t: code_point mismatch, expected 0x%08h, actual 0x%08h",
                         $time, want, got);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic              m_tready = 1'b0;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [CHAR_W-1:0] o_m_axis_tdata;

    utf8_char_board    board = new();
    logic [BYTE_W-1:0] byte_plan[$];
    bit                calm_in = 1'b0;
    bit                calm_out = 1'b0;
    bit                hold_request = 1'b0;
    int unsigned       cycle_count = 0;

    always #5 i_clk = ~i_clk;

    utf8_stream_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic logic [BYTE_W-1:0] lead_byte(input int unsigned len);
        case (len)
            0: begin
                return 8'($urandom_range(1, 8'h7F));
            end
            1: begin
                return {3'b110, 5'($urandom)};
            end
            2: begin
                return {4'b1110, 4'($urandom)};
            end
            3: begin
                return {5'b11110, 3'($urandom)};
            end
            4: begin
                return {6'b111110, 2'($urandom)};
            end
            default: begin
                return {6'b111111, 2'($urandom)};
            end
        endcase
    endfunction

    function automatic void add_sequence(input int unsigned len, input int unsigned conts);
        byte_plan.push_back(lead_byte(len));
        repeat (conts) begin
            if ($urandom_range(0, 7) == 0) begin
                byte_plan.push_back({1'b1, 7'($urandom)});
            end else begin
                byte_plan.push_back({2'b10, 6'($urandom)});
            end
        end
    endfunction

    function automatic void add_random_string();
        int unsigned chars;
        int unsigned pick;
        int unsigned len;
        chars = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
        repeat (chars) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 5);
            if (pick < 70) begin
                len = $urandom_range(0, 5);
                add_sequence(len, len);
            end else if (pick < 78) begin
                byte_plan.push_back({2'b10, 6'($urandom)});
            end else if (pick < 88) begin
                add_sequence(len, $urandom_range(0, len - 1));
                byte_plan.push_back(8'($urandom_range(1, 8'h7F)));
            end else begin
                byte_plan.push_back(8'($urandom_range(1, 255)));
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, 5);
            add_sequence(len, $urandom_range(0, len - 1));
        end
        byte_plan.push_back(8'h00);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = calm_in ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_byte(b);
    endtask

    initial begin
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (board.words_out % 64 == 0) calm_out = ($urandom_range(0, 2) == 0);
            gap = calm_out ? 0 : $urandom_range(0, 6);
            if (hold_request) begin
                gap          = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            board.check_word(o_m_axis_tdata);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d words still expected",
                 $time, cycle_count, board.pending());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned directed_count;
        byte_plan = '{8'h01, 8'h7F, 8'h80, 8'hBF,
                      8'hC3, 8'hA9,
                      8'hE2, 8'h41,
                      8'hF0, 8'h9F, 8'h98, 8'h80,
                      8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                      8'hFF, 8'hBF, 8'hFF, 8'hBF, 8'hBF, 8'hBF,
                      8'h00, 8'h00,
                      8'hC3, 8'h00};
        directed_count = byte_plan.size();
        while (byte_plan.size() < directed_count + RANDOM_BYTES) add_random_string();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (byte_plan[i]) begin
            if (i % 80 == 0) calm_in = ($urandom_range(0, 2) == 0);
            if (i == directed_count) hold_request = 1'b1;
            send_byte(byte_plan[i]);
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Decoded %0d bytes in %0d strings into %0d words.",
                 board.bytes_in, board.strings_ended, board.words_out);
        $display("Covered %0d multi-byte characters and %0d broken sequences.",
                 board.multi_byte, board.broken);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
